>>> design/rgl_pkg.sv
`timescale 1ns / 1ps

package rgl_pkg;

  // Operation of the shared add/subtract unit.
  typedef enum logic {
    OP_ADD,
    OP_SUB
  } rgl_op_e;

  // Events raised by one lcm fold step.
  typedef struct packed {
    logic overflow;
    logic undefined;
  } rgl_flags_t;

endpackage

>>> design/rgl_addsub.sv
`timescale 1ns / 1ps

module rgl_addsub import rgl_pkg::*; #(
  parameter int unsigned WIDTH = 32
) (
  input  logic [WIDTH-1:0] a_i,
  input  logic [WIDTH-1:0] b_i,
  input  rgl_op_e          op_i,
  output logic [WIDTH-1:0] sum_o,
  output logic             carry_o
);

  logic [WIDTH-1:0] b_eff;
  logic             cin;

  // Subtract as a plus inverted b plus one; carry out high means a >= b.
  assign b_eff = (op_i == OP_SUB) ? ~b_i : b_i;
  assign cin   = (op_i == OP_SUB);

  assign {carry_o, sum_o} = {1'b0, a_i} + {1'b0, b_eff} + {{WIDTH{1'b0}}, cin};

endmodule

>>> design/rgl_seq.sv
`timescale 1ns / 1ps

module rgl_seq import rgl_pkg::*; #(
  parameter int unsigned VALUE_BITS = 31
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [VALUE_BITS-1:0] gcd_i,
  input  logic [VALUE_BITS-1:0] lcm_i,
  input  logic [VALUE_BITS-1:0] value_i,
  input  logic                  lcm_hold_i,
  output logic                  done_o,
  output logic [VALUE_BITS-1:0] gcd_o,
  output logic [VALUE_BITS-1:0] lcm_o,
  output rgl_flags_t            flags_o
);

  localparam int unsigned W  = VALUE_BITS;
  localparam int unsigned CW = $clog2(VALUE_BITS + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_GCD  = 3'd1;
  localparam logic [2:0] S_SHL  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_MUL  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0]    state_q, state_d;
  logic          pass_q, pass_d;
  logic [W-1:0]  a_q, a_d;
  logic [W-1:0]  b_q, b_d;
  logic [CW-1:0] k_q, k_d;
  logic [W-1:0]  hi_q, hi_d;
  logic [W-1:0]  lo_q, lo_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [W-1:0]  gcd_res_q, gcd_res_d;
  logic [W-1:0]  lcm_res_q, lcm_res_d;
  rgl_flags_t    flags_q, flags_d;

  logic [W:0]    op_a, op_b, sum;
  rgl_op_e       op;
  logic          carry;

  rgl_addsub #(
    .WIDTH (W + 1)
  ) u_addsub (
    .a_i     (op_a),
    .b_i     (op_b),
    .op_i    (op),
    .sum_o   (sum),
    .carry_o (carry)
  );

  // Route operands to the shared unit.
  always_comb begin
    op_a = {1'b0, a_q};
    op_b = {1'b0, b_q};
    op   = OP_SUB;
    unique case (state_q)
      S_DIV: begin
        op_a = {hi_q, lo_q[W-1]};
      end
      S_MUL: begin
        op_a = {1'b0, hi_q};
        op_b = {1'b0, value_i};
        op   = OP_ADD;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_d   = state_q;
    pass_d    = pass_q;
    a_d       = a_q;
    b_d       = b_q;
    k_d       = k_q;
    hi_d      = hi_q;
    lo_d      = lo_q;
    cnt_d     = cnt_q;
    gcd_res_d = gcd_res_q;
    lcm_res_d = lcm_res_q;
    flags_d   = flags_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          a_d     = gcd_i;
          b_d     = value_i;
          k_d     = '0;
          pass_d  = 1'b0;
          state_d = S_GCD;
        end
      end
      // Binary gcd: strip common twos, halve even operands, subtract odd ones.
      S_GCD: begin
        priority if (a_q == '0) begin
          a_d     = b_q;
          state_d = S_SHL;
        end else if (b_q == '0) begin
          state_d = S_SHL;
        end else if (!a_q[0] && !b_q[0]) begin
          a_d = {1'b0, a_q[W-1:1]};
          b_d = {1'b0, b_q[W-1:1]};
          k_d = k_q + 1'b1;
        end else if (!a_q[0]) begin
          a_d = {1'b0, a_q[W-1:1]};
        end else if (!b_q[0]) begin
          b_d = {1'b0, b_q[W-1:1]};
        end else if (carry) begin
          a_d = {1'b0, sum[W-1:1]};
        end else begin
          a_d = b_q;
          b_d = a_q;
        end
      end
      // Restore the common power of two, then dispatch on the pass.
      S_SHL: begin
        priority if (k_q != '0) begin
          a_d = {a_q[W-2:0], 1'b0};
          k_d = k_q - 1'b1;
        end else if (!pass_q) begin
          gcd_res_d = a_q;
          if (lcm_hold_i) begin
            lcm_res_d = lcm_i;
            flags_d   = '0;
            state_d   = S_DONE;
          end else begin
            a_d     = lcm_i;
            b_d     = value_i;
            pass_d  = 1'b1;
            state_d = S_GCD;
          end
        end else if (a_q == '0) begin
          lcm_res_d         = '0;
          flags_d.overflow  = 1'b0;
          flags_d.undefined = 1'b1;
          state_d           = S_DONE;
        end else begin
          b_d     = a_q;
          hi_d    = '0;
          lo_d    = lcm_i;
          cnt_d   = CW'(W);
          state_d = S_DIV;
        end
      end
      // Restoring divide lcm / g, one quotient bit a cycle.
      S_DIV: begin
        hi_d  = carry ? sum[W-1:0] : op_a[W-1:0];
        lo_d  = {lo_q[W-2:0], carry};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          hi_d    = '0;
          cnt_d   = CW'(W);
          state_d = S_MUL;
        end
      end
      // Shift-add multiply quotient by value, low bit first.
      S_MUL: begin
        if (lo_q[0]) begin
          hi_d = sum[W:1];
          lo_d = {sum[0], lo_q[W-1:1]};
        end else begin
          hi_d = {1'b0, hi_q[W-1:1]};
          lo_d = {hi_q[0], lo_q[W-1:1]};
        end
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        flags_d.undefined = 1'b0;
        if (hi_q != '0) begin
          lcm_res_d        = '1;
          flags_d.overflow = 1'b1;
        end else begin
          lcm_res_d        = lo_q;
          flags_d.overflow = 1'b0;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pass_q    <= pass_d;
    a_q       <= a_d;
    b_q       <= b_d;
    k_q       <= k_d;
    hi_q      <= hi_d;
    lo_q      <= lo_d;
    cnt_q     <= cnt_d;
    gcd_res_q <= gcd_res_d;
    lcm_res_q <= lcm_res_d;
    flags_q   <= flags_d;
  end

  assign done_o  = (state_q == S_DONE);
  assign gcd_o   = gcd_res_q;
  assign lcm_o   = lcm_res_q;
  assign flags_o = flags_q;

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (b_q != '0))
    else $error("divide entered with a zero divisor");

  a_count_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_DIV) || (state_q == S_MUL)) |-> (cnt_q != '0))
    else $error("bit counter ran out during divide or multiply");

endmodule

>>> design/running_gcd_lcm_core.sv
`timescale 1ns / 1ps

// Channel  Direction  Handshake                 Payload
// in       request    in_valid_i / in_ready_o   value_i, last_item_i
// out      result     out_valid_o / out_ready_i gcd_result_o, lcm_result_o,
//                                               lcm_overflow_o, lcm_undefined_o
//
// A first request seeds the set directly; a later one runs two binary gcd passes,
// each ending in a shift that restores the common power of two, then a restoring
// divide and a shift-add multiply on one shared adder, plus dispatch states.
// A saturated lcm skips all but the first pass. Reset clears the running set.
// The request that ends a set then waits in T_EMIT to load the output register,
// longer while the previous result is still held.

module running_gcd_lcm_core import rgl_pkg::*; #(
  parameter int unsigned VALUE_BITS = 31
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [VALUE_BITS-1:0] value_i,
  input  logic                  last_item_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [VALUE_BITS-1:0] gcd_result_o,
  output logic [VALUE_BITS-1:0] lcm_result_o,
  output logic                  lcm_overflow_o,
  output logic                  lcm_undefined_o
);

  localparam int unsigned W = VALUE_BITS;

  localparam logic [1:0] T_IDLE = 2'd0;
  localparam logic [1:0] T_RUN  = 2'd1;
  localparam logic [1:0] T_EMIT = 2'd2;

  logic [1:0]   state_q, state_d;
  logic         start_q, start_d;
  logic [W-1:0] value_q, value_d;
  logic         last_q, last_d;

  // Running set state.
  logic [W-1:0] gcd_q, gcd_d;
  logic [W-1:0] lcm_q, lcm_d;
  logic         first_q, first_d;
  logic         ovf_q, ovf_d;
  logic         und_q, und_d;

  // Output register.
  logic         out_valid_q, out_valid_d;
  logic [W-1:0] gcd_out_q, gcd_out_d;
  logic [W-1:0] lcm_out_q, lcm_out_d;
  logic         ovf_out_q, ovf_out_d;
  logic         und_out_q, und_out_d;

  logic         accept;
  logic         seq_done;
  logic [W-1:0] seq_gcd, seq_lcm;
  rgl_flags_t   seq_flags;

  assign in_ready_o = (state_q == T_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // Fold one value into the running gcd and lcm. Inputs hold steady for
  // the whole run because the controller sits in T_RUN until done.
  rgl_seq #(
    .VALUE_BITS (VALUE_BITS)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_q),
    .gcd_i      (gcd_q),
    .lcm_i      (lcm_q),
    .value_i    (value_q),
    .lcm_hold_i (ovf_q),
    .done_o     (seq_done),
    .gcd_o      (seq_gcd),
    .lcm_o      (seq_lcm),
    .flags_o    (seq_flags)
  );

  always_comb begin
    state_d     = state_q;
    start_d     = 1'b0;
    value_d     = value_q;
    last_d      = last_q;
    gcd_d       = gcd_q;
    lcm_d       = lcm_q;
    first_d     = first_q;
    ovf_d       = ovf_q;
    und_d       = und_q;
    // Drop the held result once it is taken.
    out_valid_d = out_valid_q && !out_ready_i;
    gcd_out_d   = gcd_out_q;
    lcm_out_d   = lcm_out_q;
    ovf_out_d   = ovf_out_q;
    und_out_d   = und_out_q;
    unique case (state_q)
      T_IDLE: begin
        if (accept) begin
          value_d = value_i;
          last_d  = last_item_i;
          if (first_q) begin
            // Seed the set directly; no arithmetic needed.
            gcd_d   = value_i;
            lcm_d   = value_i;
            first_d = 1'b0;
            if (last_item_i) begin
              state_d = T_EMIT;
            end
          end else begin
            start_d = 1'b1;
            state_d = T_RUN;
          end
        end
      end
      T_RUN: begin
        if (seq_done) begin
          gcd_d   = seq_gcd;
          lcm_d   = seq_lcm;
          ovf_d   = ovf_q | seq_flags.overflow;
          und_d   = und_q | seq_flags.undefined;
          state_d = last_q ? T_EMIT : T_IDLE;
        end
      end
      T_EMIT: begin
        // Hold until the output register is free, then load it and clear the set.
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          gcd_out_d   = gcd_q;
          lcm_out_d   = lcm_q;
          ovf_out_d   = ovf_q;
          und_out_d   = und_q;
          gcd_d       = '0;
          lcm_d       = '0;
          first_d     = 1'b1;
          ovf_d       = 1'b0;
          und_d       = 1'b0;
          state_d     = T_IDLE;
        end
      end
      default: begin
        state_d = T_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= T_IDLE;
      start_q     <= 1'b0;
      gcd_q       <= '0;
      lcm_q       <= '0;
      first_q     <= 1'b1;
      ovf_q       <= 1'b0;
      und_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      start_q     <= start_d;
      gcd_q       <= gcd_d;
      lcm_q       <= lcm_d;
      first_q     <= first_d;
      ovf_q       <= ovf_d;
      und_q       <= und_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q   <= value_d;
    last_q    <= last_d;
    gcd_out_q <= gcd_out_d;
    lcm_out_q <= lcm_out_d;
    ovf_out_q <= ovf_out_d;
    und_out_q <= und_out_d;
  end

  assign out_valid_o     = out_valid_q;
  assign gcd_result_o    = gcd_out_q;
  assign lcm_result_o    = lcm_out_q;
  assign lcm_overflow_o  = ovf_out_q;
  assign lcm_undefined_o = und_out_q;

  a_done_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seq_done |-> (state_q == T_RUN))
    else $error("fold finished outside of a run");

  a_overflow_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && lcm_overflow_o) |-> ((lcm_result_o == '1) && !lcm_undefined_o))
    else $error("overflowed lcm not saturated");

  a_undefined_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && lcm_undefined_o) |-> (lcm_result_o == '0))
    else $error("undefined lcm not zero");

endmodule
